// ----- design/uer_pkg.sv -----
`default_nettype none

package uer_pkg;

    // field and register widths
    localparam int TRIG_W  = 8;
    localparam int GAP_W   = 20;
    localparam int SMP_W   = 4;
    localparam int UPC_W   = 8;
    localparam int DIST_W  = 28;
    localparam int CFG_W   = 20;
    localparam int CIDX_W  = 2;
    localparam int ROUND_W = 4;
    localparam int FRAC_W  = 8;
    localparam int DIV_W   = UPC_W + SMP_W;

    // register reset values
    localparam logic [TRIG_W-1:0] TRIG_RST = TRIG_W'(20);
    localparam logic [GAP_W-1:0]  GAP_RST  = GAP_W'(100000);
    localparam logic [SMP_W-1:0]  SMP_RST  = SMP_W'(5);
    localparam logic [UPC_W-1:0]  UPC_RST  = UPC_W'(58);

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_TRIG = 2'd0,
        CFG_GAP  = 2'd1,
        CFG_SMP  = 2'd2,
        CFG_UPC  = 2'd3
    } t_cfg_idx;

    // ranging phase
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_TRIG = 5'b00010,
        PH_WAIT = 5'b00100,
        PH_HIGH = 5'b01000,
        PH_GAP  = 5'b10000
    } t_phase;

    // tick handling versus averaging divide
    typedef enum logic [1:0] {
        CT_RUN = 2'b01,
        CT_DIV = 2'b10
    } t_ctl;

endpackage

`default_nettype wire

// ----- design/ultrasonic_echo_ranger.sv -----
`default_nettype none

// channel  | direction | handshake                  | word
// ---------+-----------+----------------------------+---------------------------------
// tick in  | input     | i_in_valid / o_in_stall    | i_echo_level, i_start_req
// result   | output    | o_out_valid / i_out_stall  | o_trig_level, o_busy_res,
//          |           |                            | o_done_res, o_distance_q8
// config   | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// an ordinary tick is taken straight into the output register; a new tick
// enters in the same cycle the waiting word leaves the output register. the
// tick that finishes a run shows its word only once the bit-serial restoring
// divider that forms the average is done, one quotient bit per cycle; new
// ticks are stalled while it divides.
// reset is synchronous, active low, and restores the register defaults.
// a stalled output blocks new ticks only while its register is full.
module ultrasonic_echo_ranger #(
    parameter int WIDTH_BITS  = 24,
    parameter int MAX_SAMPLES = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_echo_level,
    input  wire logic                        i_start_req,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_trig_level,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic [uer_pkg::DIST_W-1:0]       o_distance_q8,
    input  wire logic                        i_cfg_we,
    input  wire logic [uer_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  wire logic [uer_pkg::CFG_W-1:0]   i_cfg_data
);
    import uer_pkg::*;

    localparam int SUM_W = WIDTH_BITS + $clog2(MAX_SAMPLES);
    localparam int QW    = SUM_W + FRAC_W;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int EXT_W = (QW > DIST_W) ? QW : DIST_W;
    localparam int MS_W  = $clog2(MAX_SAMPLES + 1) + 1;

    // configuration
    logic [TRIG_W-1:0] r_trig_ticks;
    logic [GAP_W-1:0]  r_gap_ticks;
    logic [SMP_W-1:0]  r_sample_count;
    logic [UPC_W-1:0]  r_us_per_cm;

    // ranging state
    t_phase                 r_phase, n_phase;
    logic [GAP_W-1:0]       r_timer, n_timer;
    logic [ROUND_W-1:0]     r_round, n_round;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [WIDTH_BITS-1:0]  r_width, n_width;
    logic [DIST_W-1:0]      r_last_dist;
    logic                   done_tick;

    // divider and output
    t_ctl                   r_ctl;
    logic [CNT_W-1:0]       r_cnt;
    logic [DIV_W-1:0]       r_dvs;
    logic [DIV_W-1:0]       r_rem;
    logic [QW-1:0]          r_quo;
    logic                   r_out_valid;
    logic                   r_o_trig, r_o_busy, r_o_done;
    logic [DIST_W-1:0]      r_o_dist;

    logic                   in_acc, out_acc;
    logic [ROUND_W-1:0]     rounds_n;
    logic [UPC_W-1:0]       upc_eff;
    logic [DIV_W-1:0]       divisor;
    logic [DIV_W:0]         trial;
    logic                   trial_ge;
    logic [DIV_W-1:0]       n_rem;
    logic [EXT_W-1:0]       quo_ext;
    logic [DIST_W-1:0]      dist_sat;

    // handshakes
    assign out_acc    = r_out_valid & ~i_out_stall;
    assign o_in_stall = ~((r_ctl == CT_RUN) & (~r_out_valid | ~i_out_stall));
    assign in_acc     = i_in_valid & ~o_in_stall;

    // effective round count and divisor
    always_comb begin
        priority if (r_sample_count == '0) begin
            rounds_n = ROUND_W'(1);
        end else if (MS_W'(r_sample_count) > MS_W'(MAX_SAMPLES)) begin
            rounds_n = ROUND_W'(MAX_SAMPLES);
        end else begin
            rounds_n = ROUND_W'(r_sample_count);
        end
        upc_eff = (r_us_per_cm == '0) ? UPC_W'(1) : r_us_per_cm;
        divisor = DIV_W'(upc_eff) * DIV_W'(rounds_n);
    end

    // one tick of the ranging sequence
    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_round   = r_round;
        n_sum     = r_sum;
        n_width   = r_width;
        done_tick = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase = PH_TRIG;
                    n_timer = GAP_W'(1);
                    n_round = '0;
                    n_sum   = '0;
                    n_width = '0;
                end
            end
            PH_TRIG: begin
                if (r_timer >= GAP_W'(r_trig_ticks)) begin
                    n_phase = PH_WAIT;
                    n_timer = '0;
                end else begin
                    n_timer = r_timer + GAP_W'(1);
                end
            end
            PH_WAIT: begin
                if (i_echo_level) begin
                    n_phase = PH_HIGH;
                    n_width = WIDTH_BITS'(1);
                end
            end
            PH_HIGH: begin
                if (i_echo_level) begin
                    if (r_width != {WIDTH_BITS{1'b1}}) begin
                        n_width = r_width + WIDTH_BITS'(1);
                    end
                end else begin
                    n_sum   = r_sum + SUM_W'(r_width);
                    n_width = '0;
                    n_round = r_round + ROUND_W'(1);
                    n_phase = PH_GAP;
                    n_timer = '0;
                end
            end
            PH_GAP: begin
                if (r_timer >= r_gap_ticks) begin
                    if (r_round >= rounds_n) begin
                        done_tick = 1'b1;
                        n_phase   = PH_IDLE;
                        n_timer   = '0;
                        n_round   = '0;
                    end else begin
                        n_phase = PH_TRIG;
                        n_timer = GAP_W'(1);
                    end
                end else begin
                    n_timer = r_timer + GAP_W'(1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // restoring divide step and final saturation
    always_comb begin
        trial    = {r_rem, r_quo[QW-1]};
        trial_ge = trial >= {1'b0, r_dvs};
        n_rem    = trial_ge ? DIV_W'(trial - {1'b0, r_dvs}) : trial[DIV_W-1:0];
        quo_ext  = EXT_W'(r_quo);
        dist_sat = (quo_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : quo_ext[DIST_W-1:0];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_ticks   <= TRIG_RST;
            r_gap_ticks    <= GAP_RST;
            r_sample_count <= SMP_RST;
            r_us_per_cm    <= UPC_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRIG: r_trig_ticks   <= i_cfg_data[TRIG_W-1:0];
                CFG_GAP:  r_gap_ticks    <= i_cfg_data[GAP_W-1:0];
                CFG_SMP:  r_sample_count <= i_cfg_data[SMP_W-1:0];
                CFG_UPC:  r_us_per_cm    <= i_cfg_data[UPC_W-1:0];
                default: ;
            endcase
        end
    end

    // ranging state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_round <= '0;
            r_sum   <= '0;
            r_width <= '0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_round <= n_round;
            r_sum   <= n_sum;
            r_width <= n_width;
        end
    end

    // divider control, last result and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= CT_RUN;
            r_cnt       <= '0;
            r_last_dist <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_ctl)
                CT_RUN: begin
                    if (in_acc && done_tick) begin
                        r_ctl       <= CT_DIV;
                        r_cnt       <= CNT_W'(QW);
                        r_out_valid <= 1'b0;
                    end else if (in_acc) begin
                        r_out_valid <= 1'b1;
                    end else if (out_acc) begin
                        r_out_valid <= 1'b0;
                    end
                end
                CT_DIV: begin
                    if (r_cnt == '0) begin
                        r_ctl       <= CT_RUN;
                        r_last_dist <= dist_sat;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                default: r_ctl <= CT_RUN;
            endcase
        end
    end

    // divider datapath and output word
    always_ff @(posedge i_clk) begin
        if (r_ctl == CT_RUN) begin
            if (in_acc && done_tick) begin
                r_quo <= {r_sum, {FRAC_W{1'b0}}};
                r_rem <= '0;
                r_dvs <= divisor;
            end else if (in_acc) begin
                r_o_trig <= (n_phase == PH_TRIG);
                r_o_busy <= (n_phase != PH_IDLE);
                r_o_done <= 1'b0;
                r_o_dist <= r_last_dist;
            end
        end else if (r_cnt == '0) begin
            r_o_trig <= 1'b0;
            r_o_busy <= 1'b0;
            r_o_done <= 1'b1;
            r_o_dist <= dist_sat;
        end else begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QW-2:0], trial_ge};
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_trig_level  = r_o_trig;
    assign o_busy_res    = r_o_busy;
    assign o_done_res    = r_o_done;
    assign o_distance_q8 = r_o_dist;

endmodule

`default_nettype wire

// ----- design/uer_checker.sv -----
`default_nettype none

module uer_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic                       o_trig_level,
    input wire logic                       o_busy_res,
    input wire logic                       o_done_res,
    input wire logic [uer_pkg::DIST_W-1:0] o_distance_q8
);
    import uer_pkg::*;

    // a waiting word stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_distance_q8))
        else $error("result word dropped or changed while stalled");

    // a full, stalled output register blocks new ticks
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("tick taken while result register blocked");

    // done word ends the run
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res && !o_trig_level)
        else $error("done word shows a running run");

    // trigger only during a run
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_trig_level |-> o_busy_res)
        else $error("trigger high while idle");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_trig_level  (o_trig_level),
    .o_busy_res    (o_busy_res),
    .o_done_res    (o_done_res),
    .o_distance_q8 (o_distance_q8)
);

`default_nettype wire
